[hw/rtl/ffa_pkg.sv]
// Shared constants, types and helpers of the first-fit allocator.
`default_nettype none

package ffa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int SIZE_BITS  = 16;

    localparam int AMOUNT_W = 16;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 7;
    localparam int COUNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_REQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALLOC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [IDX_W-1:0]     idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic scan_step;
        logic do_add;
        logic do_alloc;
        logic do_miss;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fit;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

    // zero-extend or trim the 16-bit amount to the capacity width
    function automatic size_t amount_to_size(input logic [AMOUNT_W-1:0] a);
        logic [SIZE_BITS+AMOUNT_W-1:0] wide;
        wide = (SIZE_BITS + AMOUNT_W)'(a);
        return wide[SIZE_BITS-1:0];
    endfunction

    // keep the low bits of a block id that fit the result field
    function automatic logic [ID_W-1:0] count_to_id(input count_t c);
        logic [COUNT_W+ID_W-1:0] wide;
        wide = (COUNT_W + ID_W)'(c);
        return wide[ID_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ffa_in_if.sv]
// Input channel of the allocator: command and amount with valid/ready.
`default_nettype none

interface ffa_in_if
    import ffa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output cmd, output amount, input ready);
    modport sink   (input valid, input cmd, input amount, output ready);
endinterface

`default_nettype wire

[hw/rtl/ffa_out_if.sv]
// Result channel of the allocator: status and block id with valid/ready.
`default_nettype none

interface ffa_out_if
    import ffa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     block_number;

    modport source (output valid, output status, output block_number, input ready);
    modport sink   (input valid, input status, input block_number, output ready);
endinterface

`default_nettype wire

[hw/rtl/ffa_datapath.sv]
// Datapath: capacity memory, block count, scan pointer and result register.
`default_nettype none

module ffa_datapath
    import ffa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [AMOUNT_W-1:0] amount,
    input  wire ctrl_cmd_t           cmd,
    output dp_stat_t                 stat,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [STATUS_W-1:0]      out_status,
    output logic [ID_W-1:0]          out_block_number
);

    size_t mem [MAX_BLOCKS];

    size_t               amount_reg;
    count_t              count_reg,     count_next;
    count_t              scan_reg,      scan_next;
    logic                rd_valid_reg,  rd_valid_next;
    idx_t                chk_reg;
    size_t               rd_data_reg;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     id_reg;

    logic                full;
    logic                can_issue;
    logic                rd_en;
    logic                wr_en;
    idx_t                wr_addr;
    size_t               wr_data;
    logic                load_result;
    logic [STATUS_W-1:0] result_status;
    count_t              result_id;

    assign full      = (count_reg == COUNT_W'(MAX_BLOCKS));
    assign can_issue = (scan_reg < count_reg);
    assign rd_en     = cmd.scan_step && can_issue;

    assign stat.fit       = rd_valid_reg && (rd_data_reg >= amount_reg);
    assign stat.scan_done = !rd_valid_reg && !can_issue;
    assign stat.out_free  = !out_valid_reg || out_ready;

    // one write port shared by append and allocate
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = chk_reg;
        wr_data = rd_data_reg - amount_reg;
        if (cmd.do_add && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = amount_reg;
        end
        else if (cmd.do_alloc)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        scan_next     = scan_reg;
        rd_valid_next = rd_valid_reg;
        if (cmd.do_add && !full)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.latch_in)
        begin
            scan_next     = '0;
            rd_valid_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            rd_valid_next = can_issue;
            if (can_issue)
            begin
                scan_next = scan_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        load_result   = cmd.do_add || cmd.do_alloc || cmd.do_miss;
        result_status = STATUS_NONE;
        result_id     = '0;
        if (cmd.do_add)
        begin
            result_status = full ? STATUS_FULL : STATUS_ADDED;
            result_id     = full ? '0 : count_reg + 1'b1;
        end
        else if (cmd.do_alloc)
        begin
            result_status = STATUS_ALLOC;
            result_id     = COUNT_W'(chk_reg) + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            amount_reg <= amount_to_size(amount);
        end
        if (rd_en)
        begin
            chk_reg <= scan_reg[IDX_W-1:0];
        end
        if (load_result)
        begin
            status_reg <= result_status;
            id_reg     <= count_to_id(result_id);
        end
    end

    // capacity memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_reg[IDX_W-1:0]];
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = status_reg;
    assign out_block_number = id_reg;

endmodule

`default_nettype wire

[hw/rtl/ffa_ctrl.sv]
// Controller: sequences one transaction at a time through add or scan.
`default_nettype none

module ffa_ctrl
    import ffa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_cmd,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output ctrl_cmd_t     cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_cmd == CMD_ADD) ? ST_ADD : ST_SCAN;
                end
            end
            ST_ADD, ST_HIT, ST_MISS:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                priority if (stat.fit)
                begin
                    state_next = ST_HIT;
                end
                else if (stat.scan_done)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.latch_in  = (state_reg == ST_IDLE) && in_valid;
        // hold the pointer once a fitting block has been seen
        cmd.scan_step = (state_reg == ST_SCAN) && !stat.fit;
        cmd.do_add    = (state_reg == ST_ADD)  && stat.out_free;
        cmd.do_alloc  = (state_reg == ST_HIT)  && stat.out_free;
        cmd.do_miss   = (state_reg == ST_MISS) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/first_fit_allocator.sv]
// Top level of the first-fit allocator: controller plus datapath.
//
//   channel  | dir | payload              | handshake
//   ---------+-----+----------------------+--------------------------------
//   in_ch    | in  | cmd, amount          | valid/ready, taken on both high
//   out_ch   | out | status, block_number | valid/ready, taken on both high
//
// An add goes from IDLE to ADD and loads its result once the output register is
// free; a request reads one block a cycle in SCAN, then HIT or MISS loads its
// result the same way. Input is ready again in IDLE, entered as a result loads.
// Reset clears the block count and handshake state; memory needs no clearing.
// A result waits in the output register; the next transaction is accepted
// meanwhile, and work only halts when a new result is due and it is still full.
`default_nettype none

module first_fit_allocator
    import ffa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ffa_in_if.sink     in_ch,
    ffa_out_if.source  out_ch
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .amount           (in_ch.amount),
        .cmd              (cmd),
        .stat             (stat),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .out_status       (out_ch.status),
        .out_block_number (out_ch.block_number)
    );

endmodule

`default_nettype wire
